### hdl/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types, codes and tables of the relay frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rfd_pkg;

    localparam int DEF_MAX_PAYLOAD = 65536;
    localparam int DEF_MAX_ARGS    = 4096;

    localparam int HDR_BYTES = 10;
    localparam logic [16:0] POS_MAX = 17'h1FFFF;

    localparam logic [7:0] MAGIC [4] = '{8'h4C, 8'h51, 8'h43, 8'h49};

    localparam logic [7:0] KIND_REQUEST = 8'd1;
    localparam logic [7:0] KIND_REPLY   = 8'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_EXPECT_REPLY = 2'd0;
    localparam logic [1:0] CFG_VERSION      = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD  = 2'd2;
    localparam logic [1:0] CFG_MAX_ARGS     = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LEN    = 3'd1,
        PH_BODY   = 3'd2,
        PH_COUNT  = 3'd3,
        PH_ACCEPT = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    typedef enum logic [3:0] {
        ST_PENDING  = 4'd0,
        ST_OK       = 4'd1,
        ST_SHORT    = 4'd2,
        ST_MAGIC    = 4'd3,
        ST_KIND     = 4'd4,
        ST_VERSION  = 4'd5,
        ST_LARGE    = 4'd6,
        ST_MISMATCH = 4'd7,
        ST_TRUNC    = 4'd8,
        ST_OVERRUN  = 4'd9,
        ST_UTF8     = 4'd10,
        ST_ARGS     = 4'd11,
        ST_ACCEPT   = 4'd12,
        ST_TRAIL    = 4'd13
    } status_t;

    // continuation byte ranges selected by the lead byte
    typedef enum logic [2:0] {
        UB_ANY  = 3'd0,
        UB_E0   = 3'd1,
        UB_ED   = 3'd2,
        UB_F0   = 3'd3,
        UB_F4   = 3'd4
    } ubound_t;

    typedef struct packed {
        logic [1:0] pending;
        ubound_t    bounds;
    } utf8_state_t;

    function automatic logic [7:0] cont_lo(input ubound_t k);
        logic [7:0] r;
        unique case (k)
            UB_E0:   r = 8'hA0;
            UB_F0:   r = 8'h90;
            default: r = 8'h80;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] cont_hi(input ubound_t k);
        logic [7:0] r;
        unique case (k)
            UB_ED:   r = 8'h9F;
            UB_F4:   r = 8'h8F;
            default: r = 8'hBF;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/rfd_utf8.sv
// ----------------------------------------------------------------------------
// rfd_utf8
// Strict UTF-8 byte checker: one byte against the running sequence state.
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_utf8 (
    input  wire logic [7:0]          data_byte,
    input  wire rfd_pkg::utf8_state_t cur,
    output logic                     ok,
    output rfd_pkg::utf8_state_t     nxt
);

    always_comb begin
        ok  = 1'b1;
        nxt = cur;
        if (cur.pending == 2'd0) begin
            nxt.bounds = rfd_pkg::UB_ANY;
            if (data_byte < 8'h80) begin
                ok = 1'b1;
            end else if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
                nxt.pending = 2'd1;
            end else if (data_byte == 8'hE0) begin
                nxt.pending = 2'd2;
                nxt.bounds  = rfd_pkg::UB_E0;
            end else if (data_byte == 8'hED) begin
                nxt.pending = 2'd2;
                nxt.bounds  = rfd_pkg::UB_ED;
            end else if (data_byte >= 8'hE1 && data_byte <= 8'hEF) begin
                nxt.pending = 2'd2;
            end else if (data_byte == 8'hF0) begin
                nxt.pending = 2'd3;
                nxt.bounds  = rfd_pkg::UB_F0;
            end else if (data_byte == 8'hF4) begin
                nxt.pending = 2'd3;
                nxt.bounds  = rfd_pkg::UB_F4;
            end else if (data_byte >= 8'hF1 && data_byte <= 8'hF3) begin
                nxt.pending = 2'd3;
            end else begin
                ok = 1'b0;
            end
        end else begin
            if (data_byte < rfd_pkg::cont_lo(cur.bounds) ||
                data_byte > rfd_pkg::cont_hi(cur.bounds)) begin
                ok = 1'b0;
            end else begin
                nxt.pending = cur.pending - 2'd1;
                nxt.bounds  = rfd_pkg::UB_ANY;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/relay_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// relay_frame_decoder_core
// Streaming relay frame decoder, one frame byte per request.
// ----------------------------------------------------------------------------
// Input: s_tdata carries one frame byte, s_tlast marks the frame's final byte.
// Output: one result per input byte. m_tlast marks the result of a frame's
// last byte, which carries the final status, accepted flag and arg count;
// other results carry streamed string bytes or nothing.
// Each result is registered: m_tvalid rises in the cycle after an input byte is accepted.
// Throughput: one byte per cycle while the receiver does not stall; all header and
// payload parsing is done by the next-state logic ahead of the output register.
// A stalled receiver holds the output register; s_tready is high whenever
// the output register is empty or is being drained in the same cycle.
// Reset (aresetn low, synchronous) clears the frame state, empties the output
// register and loads the default configuration. The state is also cleared
// after every frame's last byte. Configuration is written through cfg_we, cfg_index
// and cfg_wdata, by the user only while the decoder is idle; the block does not check.
// ----------------------------------------------------------------------------
`default_nettype none

module relay_frame_decoder_core #(
    parameter int MAX_PAYLOAD_BYTES = rfd_pkg::DEF_MAX_PAYLOAD,
    parameter int MAX_ARGUMENTS     = rfd_pkg::DEF_MAX_ARGS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // frame_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // text_byte, text_valid, text_index, text_end,
                                        // status, accepted, arg_count; zero fill
    output logic             m_tlast,   // frame_done
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [16:0] cfg_wdata
);

    // configuration
    logic        expect_reply_reg;
    logic [7:0]  version_reg;
    logic [16:0] max_payload_reg;
    logic [12:0] max_args_reg;

    // frame state
    logic [16:0]           pos_reg, pos_next;
    logic [31:0]           dlen_reg, dlen_next;
    rfd_pkg::status_t      herr_reg, herr_next;
    rfd_pkg::phase_t       phase_reg, phase_next;
    logic [31:0]           shift_reg, shift_next;
    logic [16:0]           rem_reg, rem_next;
    logic [12:0]           arg_reg, arg_next;
    logic [12:0]           cnt_reg, cnt_next;
    rfd_pkg::utf8_state_t  u8_reg, u8_next, u8_chk;
    rfd_pkg::status_t      perr_reg, perr_next;
    logic                  acc_reg, acc_next;
    logic                  u8_ok;

    // result register
    logic                  m_valid_reg;
    logic [7:0]            o_byte_reg, o_byte_next;
    logic                  o_tv_reg, o_tv_next;
    logic [12:0]           o_idx_reg, o_idx_next;
    logic                  o_end_reg, o_end_next;
    logic                  o_done_reg, o_done_next;
    rfd_pkg::status_t      o_st_reg, o_st_next;
    logic                  o_acc_reg, o_acc_next;
    logic [12:0]           o_cnt_reg, o_cnt_next;

    logic s_fire;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    rfd_utf8 u_utf8 (
        .data_byte (s_tdata),
        .cur       (u8_reg),
        .ok        (u8_ok),
        .nxt       (u8_chk)
    );

    always_comb begin
        logic [16:0]      p;
        logic [16:0]      off;
        logic [31:0]      ra;
        logic [31:0]      v;
        logic             do_enter;
        rfd_pkg::phase_t  enter_ph;
        logic [31:0]      enter_rem;
        logic             do_finish;
        logic [32:0]      total;

        p          = pos_reg;
        pos_next   = (p < rfd_pkg::POS_MAX) ? p + 17'd1 : p;
        dlen_next  = dlen_reg;
        herr_next  = herr_reg;
        phase_next = phase_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        arg_next   = arg_reg;
        cnt_next   = cnt_reg;
        u8_next    = u8_reg;
        perr_next  = perr_reg;
        acc_next   = acc_reg;

        o_byte_next = '0;
        o_tv_next   = 1'b0;
        o_idx_next  = '0;
        o_end_next  = 1'b0;
        o_done_next = 1'b0;
        o_st_next   = rfd_pkg::ST_PENDING;
        o_acc_next  = 1'b0;
        o_cnt_next  = '0;

        off       = p - 17'(rfd_pkg::HDR_BYTES);
        ra        = dlen_reg - {15'd0, off} - 32'd1;
        v         = {shift_reg[23:0], s_tdata};
        do_enter  = 1'b0;
        enter_ph  = rfd_pkg::PH_IDLE;
        enter_rem = '0;
        do_finish = 1'b0;
        total     = '0;

        if (p < 17'd4) begin
            if (herr_reg == rfd_pkg::ST_PENDING && s_tdata != rfd_pkg::MAGIC[p[1:0]])
                herr_next = rfd_pkg::ST_MAGIC;
        end else if (p == 17'd4) begin
            if (herr_reg == rfd_pkg::ST_PENDING &&
                s_tdata != (expect_reply_reg ? rfd_pkg::KIND_REPLY : rfd_pkg::KIND_REQUEST))
                herr_next = rfd_pkg::ST_KIND;
        end else if (p == 17'd5) begin
            if (herr_reg == rfd_pkg::ST_PENDING && s_tdata != version_reg)
                herr_next = rfd_pkg::ST_VERSION;
        end else if (p < 17'(rfd_pkg::HDR_BYTES)) begin
            dlen_next = {dlen_reg[23:0], s_tdata};
            if (p == 17'(rfd_pkg::HDR_BYTES - 1) && herr_reg == rfd_pkg::ST_PENDING) begin
                if (dlen_next > {15'd0, max_payload_reg}) begin
                    herr_next = rfd_pkg::ST_LARGE;
                end else begin
                    do_enter  = 1'b1;
                    enter_ph  = expect_reply_reg ? rfd_pkg::PH_ACCEPT : rfd_pkg::PH_LEN;
                    enter_rem = dlen_next;
                end
            end
        end else if (herr_reg == rfd_pkg::ST_PENDING && perr_reg == rfd_pkg::ST_PENDING &&
                     (phase_reg == rfd_pkg::PH_LEN || phase_reg == rfd_pkg::PH_BODY ||
                      phase_reg == rfd_pkg::PH_COUNT || phase_reg == rfd_pkg::PH_ACCEPT) &&
                     {15'd0, off} < dlen_reg) begin
            unique case (phase_reg)
                rfd_pkg::PH_LEN, rfd_pkg::PH_COUNT: begin
                    shift_next = v;
                    rem_next   = rem_reg + 17'd1;
                    if (rem_next >= 17'd4) begin
                        if (phase_reg == rfd_pkg::PH_LEN) begin
                            if (v > ra) begin
                                perr_next = rfd_pkg::ST_OVERRUN;
                            end else if (v == 32'd0) begin
                                o_end_next = 1'b1;
                                o_idx_next = arg_reg;
                                do_finish  = 1'b1;
                            end else begin
                                phase_next = rfd_pkg::PH_BODY;
                                shift_next = '0;
                                rem_next   = v[16:0];
                                u8_next    = '0;
                            end
                        end else if (v > {19'd0, max_args_reg}) begin
                            perr_next = rfd_pkg::ST_ARGS;
                        end else begin
                            cnt_next  = v[12:0];
                            do_enter  = 1'b1;
                            enter_rem = ra;
                            if (expect_reply_reg) begin
                                enter_ph = rfd_pkg::PH_LEN;
                            end else if (v == 32'd0) begin
                                enter_ph = rfd_pkg::PH_DONE;
                            end else begin
                                arg_next = 13'd1;
                                enter_ph = rfd_pkg::PH_LEN;
                            end
                        end
                    end
                end
                rfd_pkg::PH_ACCEPT: begin
                    if (s_tdata > 8'd1) begin
                        perr_next = rfd_pkg::ST_ACCEPT;
                    end else begin
                        acc_next  = s_tdata[0];
                        do_enter  = 1'b1;
                        enter_ph  = rfd_pkg::PH_COUNT;
                        enter_rem = ra;
                    end
                end
                default: begin
                    if (!u8_ok) begin
                        perr_next = rfd_pkg::ST_UTF8;
                    end else begin
                        u8_next     = u8_chk;
                        o_tv_next   = 1'b1;
                        o_byte_next = s_tdata;
                        o_idx_next  = arg_reg;
                        rem_next    = rem_reg - 17'd1;
                        if (rem_next == 17'd0) begin
                            if (u8_chk.pending != 2'd0) begin
                                perr_next = rfd_pkg::ST_UTF8;
                            end else begin
                                o_end_next = 1'b1;
                                do_finish  = 1'b1;
                            end
                        end
                    end
                end
            endcase
        end

        if (do_finish) begin
            do_enter  = 1'b1;
            enter_rem = ra;
            if (expect_reply_reg) begin
                enter_ph = rfd_pkg::PH_DONE;
            end else if (arg_reg == 13'd0) begin
                enter_ph = rfd_pkg::PH_COUNT;
            end else if (arg_reg < cnt_reg) begin
                arg_next = arg_reg + 13'd1;
                enter_ph = rfd_pkg::PH_LEN;
            end else begin
                enter_ph = rfd_pkg::PH_DONE;
            end
        end

        if (do_enter) begin
            phase_next = enter_ph;
            shift_next = '0;
            rem_next   = '0;
            if ((enter_ph == rfd_pkg::PH_LEN || enter_ph == rfd_pkg::PH_COUNT) &&
                enter_rem < 32'd4)
                perr_next = rfd_pkg::ST_TRUNC;
            else if (enter_ph == rfd_pkg::PH_ACCEPT && enter_rem == 32'd0)
                perr_next = rfd_pkg::ST_TRUNC;
            else if (enter_ph == rfd_pkg::PH_DONE && enter_rem != 32'd0)
                perr_next = rfd_pkg::ST_TRAIL;
        end

        if (s_tlast) begin
            total       = {1'b0, dlen_next} + 33'(rfd_pkg::HDR_BYTES);
            o_done_next = 1'b1;
            priority if (pos_next < 17'(rfd_pkg::HDR_BYTES))
                o_st_next = rfd_pkg::ST_SHORT;
            else if (herr_next != rfd_pkg::ST_PENDING)
                o_st_next = herr_next;
            else if (pos_next >= rfd_pkg::POS_MAX || total != {16'd0, pos_next})
                o_st_next = rfd_pkg::ST_MISMATCH;
            else if (perr_next != rfd_pkg::ST_PENDING)
                o_st_next = perr_next;
            else if (phase_next != rfd_pkg::PH_DONE)
                o_st_next = rfd_pkg::ST_TRUNC;
            else
                o_st_next = rfd_pkg::ST_OK;
            if (o_st_next == rfd_pkg::ST_OK) begin
                o_acc_next = expect_reply_reg ? acc_next : 1'b0;
                o_cnt_next = cnt_next;
            end
            pos_next   = '0;
            dlen_next  = '0;
            herr_next  = rfd_pkg::ST_PENDING;
            phase_next = rfd_pkg::PH_IDLE;
            shift_next = '0;
            rem_next   = '0;
            arg_next   = '0;
            cnt_next   = '0;
            u8_next    = '0;
            perr_next  = rfd_pkg::ST_PENDING;
            acc_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_reply_reg <= 1'b0;
            version_reg      <= 8'd1;
            max_payload_reg  <= 17'(MAX_PAYLOAD_BYTES);
            max_args_reg     <= 13'(MAX_ARGUMENTS);
            pos_reg          <= '0;
            dlen_reg         <= '0;
            herr_reg         <= rfd_pkg::ST_PENDING;
            phase_reg        <= rfd_pkg::PH_IDLE;
            shift_reg        <= '0;
            rem_reg          <= '0;
            arg_reg          <= '0;
            cnt_reg          <= '0;
            u8_reg           <= '0;
            perr_reg         <= rfd_pkg::ST_PENDING;
            acc_reg          <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    rfd_pkg::CFG_EXPECT_REPLY: expect_reply_reg <= cfg_wdata[0];
                    rfd_pkg::CFG_VERSION:      version_reg      <= cfg_wdata[7:0];
                    rfd_pkg::CFG_MAX_PAYLOAD:  max_payload_reg  <= cfg_wdata;
                    rfd_pkg::CFG_MAX_ARGS:     max_args_reg     <= cfg_wdata[12:0];
                    default:                   ;
                endcase
            end
            if (s_fire) begin
                pos_reg     <= pos_next;
                dlen_reg    <= dlen_next;
                herr_reg    <= herr_next;
                phase_reg   <= phase_next;
                shift_reg   <= shift_next;
                rem_reg     <= rem_next;
                arg_reg     <= arg_next;
                cnt_reg     <= cnt_next;
                u8_reg      <= u8_next;
                perr_reg    <= perr_next;
                acc_reg     <= acc_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            o_byte_reg <= o_byte_next;
            o_tv_reg   <= o_tv_next;
            o_idx_reg  <= o_idx_next;
            o_end_reg  <= o_end_next;
            o_done_reg <= o_done_next;
            o_st_reg   <= o_st_next;
            o_acc_reg  <= o_acc_next;
            o_cnt_reg  <= o_cnt_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = o_done_reg;
    assign m_tdata  = {7'd0, o_cnt_reg, o_acc_reg, o_st_reg, o_end_reg,
                       o_idx_reg, o_tv_reg, o_byte_reg};

    a_status_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (o_done_reg == (o_st_reg != rfd_pkg::ST_PENDING)))
        else $error("status must be set exactly on frame end");

    a_acc_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (o_acc_reg || o_cnt_reg != 13'd0) |-> o_st_reg == rfd_pkg::ST_OK)
        else $error("accepted/arg_count outside an ok frame end");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tlast |=> pos_reg == 17'd0 && phase_reg == rfd_pkg::PH_IDLE)
        else $error("frame state not cleared after last byte");

    a_text_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && o_tv_next |-> herr_reg == rfd_pkg::ST_PENDING &&
            perr_reg == rfd_pkg::ST_PENDING)
        else $error("text streamed after an error");

endmodule

`default_nettype wire
